FILE: src/toeq_pkg.sv
`default_nettype none
package toeq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [31:0] event_time;
		logic [7:0]  event_target;
		logic [7:0]  event_kind;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        popped_valid;
		logic [31:0] popped_time;
		logic [7:0]  popped_target;
		logic [7:0]  popped_kind;
		logic [6:0]  entry_count;
	} result_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/toeq_cell.sv
`default_nettype none
module toeq_cell #(
	parameter int TIME_W = 32,
	parameter int NODE_W = 8
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  toeq_pkg::cell_ctrl_t     ctrl,
	input  wire [TIME_W-1:0]         new_time,
	input  wire [NODE_W-1:0]         new_target,
	input  wire [7:0]                new_kind,
	input  wire                      left_valid,
	input  wire                      left_ge,
	input  wire [TIME_W-1:0]         left_time,
	input  wire [NODE_W-1:0]         left_target,
	input  wire [7:0]                left_kind,
	input  wire                      right_valid,
	input  wire [TIME_W-1:0]         right_time,
	input  wire [NODE_W-1:0]         right_target,
	input  wire [7:0]                right_kind,
	output logic                     valid,
	output logic                     ge,
	output logic [TIME_W-1:0]        time_val,
	output logic [NODE_W-1:0]        target_val,
	output logic [7:0]               kind_val
);

	logic              valid_q;
	logic [TIME_W-1:0] time_q;
	logic [NODE_W-1:0] target_q;
	logic [7:0]        kind_q;

	// queue is sorted, so ge is monotone along the row
	assign ge         = valid_q && (time_q >= new_time);
	assign valid      = valid_q;
	assign time_val   = time_q;
	assign target_val = target_q;
	assign kind_val   = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q | left_valid;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_ge) begin
				time_q   <= left_time;
				target_q <= left_target;
				kind_q   <= left_kind;
			end else if (ge || !valid_q) begin
				// first slot at or after the new time, or first free slot
				time_q   <= new_time;
				target_q <= new_target;
				kind_q   <= new_kind;
			end
		end else if (ctrl.pop) begin
			time_q   <= right_time;
			target_q <= right_target;
			kind_q   <= right_kind;
		end
	end

endmodule
`default_nettype wire

FILE: src/time_ordered_event_queue.sv
// Time-ordered event queue: a sorted row of QUEUE_DEPTH cells, earliest event in cell 0.
// Command channel: request is taken at a rising edge where start is high and busy is low.
// busy is held low; every cycle can carry a command.
// opcode insert places the event ahead of the first stored event whose time is greater
// than or equal to its own, so the newest of equal times leaves first; opcode pop
// removes the earliest event.
// Result channel: done pulses for one cycle, in the cycle after the command transfer,
// with status, the popped event (pop only) and the count after the operation.
// Throughput is 1 command per cycle: every cell compares its time against the new one
// in parallel and shifts one place toward or away from its neighbor in the same edge.
// Insert into a full queue reports full and leaves the queue unchanged; pop of an
// empty queue reports empty with zero event fields.
// Reset clears all cell valid bits and the count; no clearing pass is needed.
// The receiver cannot stall: each result is held only until the next command is taken.
`default_nettype none
module time_ordered_event_queue #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 32,
	parameter int NODE_BITS   = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  toeq_pkg::request_t  request,
	output logic                busy,
	output logic                done,
	output toeq_pkg::result_t   result
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                 accept;
	logic                 full;
	logic                 empty;
	toeq_pkg::cell_ctrl_t ctrl;

	logic [TIME_BITS+31:0] time_in_ext;
	logic [NODE_BITS+7:0]  node_in_ext;
	logic [TIME_BITS-1:0]  new_time;
	logic [NODE_BITS-1:0]  new_target;

	logic                 c_valid  [QUEUE_DEPTH];
	logic                 c_ge     [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] c_time   [QUEUE_DEPTH];
	logic [NODE_BITS-1:0] c_target [QUEUE_DEPTH];
	logic [7:0]           c_kind   [QUEUE_DEPTH];

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nx;
	logic [CNT_W+6:0]     count_ext;
	logic                 done_q;
	toeq_pkg::result_t    res_q;
	toeq_pkg::result_t    res_nx;
	logic [TIME_BITS+31:0] time_out_ext;
	logic [NODE_BITS+7:0]  node_out_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = c_valid[QUEUE_DEPTH-1];
	assign empty  = !c_valid[0];

	assign ctrl.ins = accept && (request.opcode == toeq_pkg::OP_INSERT) && !full;
	assign ctrl.pop = accept && (request.opcode == toeq_pkg::OP_POP) && !empty;

	assign time_in_ext = {{TIME_BITS{1'b0}}, request.event_time};
	assign node_in_ext = {{NODE_BITS{1'b0}}, request.event_target};
	assign new_time    = time_in_ext[TIME_BITS-1:0];
	assign new_target  = node_in_ext[NODE_BITS-1:0];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 l_valid;
		logic                 l_ge;
		logic [TIME_BITS-1:0] l_time;
		logic [NODE_BITS-1:0] l_target;
		logic [7:0]           l_kind;
		logic                 r_valid;
		logic [TIME_BITS-1:0] r_time;
		logic [NODE_BITS-1:0] r_target;
		logic [7:0]           r_kind;

		if (i == 0) begin : g_head
			assign l_valid  = 1'b1;
			assign l_ge     = 1'b0;
			assign l_time   = '0;
			assign l_target = '0;
			assign l_kind   = '0;
		end else begin : g_left
			assign l_valid  = c_valid[i-1];
			assign l_ge     = c_ge[i-1];
			assign l_time   = c_time[i-1];
			assign l_target = c_target[i-1];
			assign l_kind   = c_kind[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_valid  = 1'b0;
			assign r_time   = '0;
			assign r_target = '0;
			assign r_kind   = '0;
		end else begin : g_right
			assign r_valid  = c_valid[i+1];
			assign r_time   = c_time[i+1];
			assign r_target = c_target[i+1];
			assign r_kind   = c_kind[i+1];
		end

		toeq_cell #(
			.TIME_W(TIME_BITS),
			.NODE_W(NODE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_time    (new_time),
			.new_target  (new_target),
			.new_kind    (request.event_kind),
			.left_valid  (l_valid),
			.left_ge     (l_ge),
			.left_time   (l_time),
			.left_target (l_target),
			.left_kind   (l_kind),
			.right_valid (r_valid),
			.right_time  (r_time),
			.right_target(r_target),
			.right_kind  (r_kind),
			.valid       (c_valid[i]),
			.ge          (c_ge[i]),
			.time_val    (c_time[i]),
			.target_val  (c_target[i]),
			.kind_val    (c_kind[i])
		);
	end

	always_comb begin
		count_nx = count_q;
		if (ctrl.ins) begin
			count_nx = count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	assign count_ext    = {7'b0, count_nx};
	assign time_out_ext = {32'b0, c_time[0]};
	assign node_out_ext = {8'b0, c_target[0]};

	always_comb begin
		res_nx             = '0;
		res_nx.status      = toeq_pkg::ST_OK;
		res_nx.entry_count = count_ext[6:0];
		if (request.opcode == toeq_pkg::OP_INSERT) begin
			if (full) begin
				res_nx.status = toeq_pkg::ST_FULL;
			end
		end else if (empty) begin
			res_nx.status = toeq_pkg::ST_EMPTY;
		end else begin
			res_nx.popped_valid  = 1'b1;
			res_nx.popped_time   = time_out_ext[31:0];
			res_nx.popped_target = node_out_ext[7:0];
			res_nx.popped_kind   = c_kind[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nx;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nx;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

FILE: tb/time_ordered_event_queue_tb.sv
`timescale 1ns / 1ps
module time_ordered_event_queue_tb;

	localparam int          DEPTH         = 64;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int          DIRECTED_ROWS = 16;
	localparam int unsigned PHASE_ITEMS   = 380;

	typedef struct packed {
		logic [31:0] stamp;
		logic [7:0]  target;
		logic [7:0]  kind;
	} sched_event_t;

	typedef struct {
		toeq_pkg::request_t req;
		bit                 typed;
		toeq_pkg::result_t  want;
	} stim_row_t;

	typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	toeq_pkg::request_t request;
	logic               busy;
	logic               done;
	toeq_pkg::result_t  result;

	sched_event_t      schedule [$];
	toeq_pkg::result_t pending_results [$];
	stim_row_t         directed_rows [DIRECTED_ROWS];
	int unsigned       mismatch_count;
	int unsigned       cycle_count;
	int unsigned       sender_idle_pct;

	time_ordered_event_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sorted insert / pop of the earliest event, on the testbench's own schedule
	function automatic toeq_pkg::result_t apply_to_schedule(input toeq_pkg::request_t req);
		toeq_pkg::result_t res;
		int unsigned pos;
		sched_event_t ev;
		res = '0;
		res.status = toeq_pkg::ST_OK;
		if (req.opcode == toeq_pkg::OP_INSERT) begin
			if (schedule.size() >= DEPTH) begin
				res.status = toeq_pkg::ST_FULL;
			end else begin
				pos = 0;
				// stop at the first stored time >= new time, so equal times go newest first
				while (pos < schedule.size() && schedule[pos].stamp < req.event_time)
					pos++;
				ev.stamp  = req.event_time;
				ev.target = req.event_target;
				ev.kind   = req.event_kind;
				schedule.insert(pos, ev);
			end
		end else if (schedule.size() == 0) begin
			res.status = toeq_pkg::ST_EMPTY;
		end else begin
			ev = schedule.pop_front();
			res.popped_valid  = 1'b1;
			res.popped_time   = ev.stamp;
			res.popped_target = ev.target;
			res.popped_kind   = ev.kind;
		end
		res.entry_count = 7'(schedule.size());
		return res;
	endfunction

	function automatic toeq_pkg::request_t random_request(input logic op);
		toeq_pkg::request_t r;
		r.opcode = op;
		case ($urandom_range(3))
			0: r.event_time = 32'($urandom_range(7)) << 16;   // clustered, forces ties
			1: r.event_time = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			default: r.event_time = $urandom;
		endcase
		r.event_target = 8'($urandom);
		r.event_kind   = 8'($urandom);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_result(input toeq_pkg::result_t got, input toeq_pkg::result_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
		if (got.popped_valid !== want.popped_valid)
			report_mismatch($sformatf("popped_valid got %0b want %0b",
				got.popped_valid, want.popped_valid));
		if (got.popped_time !== want.popped_time)
			report_mismatch($sformatf("popped_time got %h want %h",
				got.popped_time, want.popped_time));
		if (got.popped_target !== want.popped_target)
			report_mismatch($sformatf("popped_target got %h want %h",
				got.popped_target, want.popped_target));
		if (got.popped_kind !== want.popped_kind)
			report_mismatch($sformatf("popped_kind got %h want %h",
				got.popped_kind, want.popped_kind));
		if (got.entry_count !== want.entry_count)
			report_mismatch($sformatf("entry_count got %0d want %0d",
				got.entry_count, want.entry_count));
	endtask

	// one command transfer; the expectation is queued at the transfer edge
	task automatic issue(input toeq_pkg::request_t req, input bit typed,
		input toeq_pkg::result_t want);
		toeq_pkg::result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = apply_to_schedule(req);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned item_budget);
		int unsigned issued;
		int unsigned extra;
		int unsigned burst_len;
		burst_t burst;
		issued = 0;
		burst = BURST_FILL;
		while (issued < item_budget) begin
			case (burst)
				BURST_FILL: begin
					while (schedule.size() < DEPTH) begin
						issue(random_request(toeq_pkg::OP_INSERT), 1'b0, '0);
						issued++;
					end
					extra = $urandom_range(4, 1);
					repeat (extra) issue(random_request(toeq_pkg::OP_INSERT), 1'b0, '0);
					issued += extra;
				end
				BURST_DRAIN: begin
					while (schedule.size() != 0) begin
						issue(random_request(toeq_pkg::OP_POP), 1'b0, '0);
						issued++;
					end
					extra = $urandom_range(3, 1);
					repeat (extra) issue(random_request(toeq_pkg::OP_POP), 1'b0, '0);
					issued += extra;
				end
				default: begin
					burst_len = $urandom_range(60, 10);
					repeat (burst_len)
						issue(random_request(($urandom_range(99) < 55) ?
							toeq_pkg::OP_INSERT : toeq_pkg::OP_POP), 1'b0, '0);
					issued += burst_len;
				end
			endcase
			// every phase starts with a full fill and a full drain
			if (burst == BURST_FILL && issued <= DEPTH + 4)
				burst = BURST_DRAIN;
			else
				case ($urandom_range(9))
					0: burst = BURST_FILL;
					1: burst = BURST_DRAIN;
					default: burst = BURST_MIXED;
				endcase
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0)
				report_mismatch("result with no transfer pending");
			else
				check_result(result, pending_results.pop_front());
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** time_ordered_event_queue: FAILED **");
			$finish;
		end
	end

	initial begin
		mismatch_count  = 0;
		cycle_count     = 0;
		sender_idle_pct = 11;
		start   <= 1'b0;
		request <= '0;
		arst_n  <= 1'b0;

		directed_rows[0]  = '{'{toeq_pkg::OP_POP, 32'hFFFF_FFFF, 8'hFF, 8'hFF}, 1'b1,
			'{toeq_pkg::ST_EMPTY, 1'b0, 32'h0, 8'h0, 8'h0, 7'd0}};
		directed_rows[1]  = '{'{toeq_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hFF}, 1'b1,
			'{toeq_pkg::ST_OK, 1'b0, 32'h0, 8'h0, 8'h0, 7'd1}};
		directed_rows[2]  = '{'{toeq_pkg::OP_INSERT, 32'h0, 8'h00, 8'h00}, 1'b1,
			'{toeq_pkg::ST_OK, 1'b0, 32'h0, 8'h0, 8'h0, 7'd2}};
		directed_rows[3]  = '{'{toeq_pkg::OP_INSERT, 32'h0001_0000, 8'h55, 8'hAA}, 1'b0, '0};
		// same time again: must leave ahead of the previous one
		directed_rows[4]  = '{'{toeq_pkg::OP_INSERT, 32'h0001_0000, 8'hAA, 8'h55}, 1'b0, '0};
		directed_rows[5]  = '{'{toeq_pkg::OP_INSERT, 32'h0000_8000, 8'h0F, 8'hF0}, 1'b0, '0};
		directed_rows[6]  = '{'{toeq_pkg::OP_POP, 32'h0, 8'h0, 8'h0}, 1'b1,
			'{toeq_pkg::ST_OK, 1'b1, 32'h0, 8'h00, 8'h00, 7'd4}};
		directed_rows[7]  = '{'{toeq_pkg::OP_POP, 32'h1234_5678, 8'h5A, 8'hA5}, 1'b0, '0};
		directed_rows[8]  = '{'{toeq_pkg::OP_POP, 32'h0, 8'h0, 8'h0}, 1'b0, '0};
		directed_rows[9]  = '{'{toeq_pkg::OP_POP, 32'h0, 8'h0, 8'h0}, 1'b0, '0};
		directed_rows[10] = '{'{toeq_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'h01, 8'h02}, 1'b0, '0};
		directed_rows[11] = '{'{toeq_pkg::OP_POP, 32'h0, 8'h0, 8'h0}, 1'b1,
			'{toeq_pkg::ST_OK, 1'b1, 32'hFFFF_FFFF, 8'h01, 8'h02, 7'd1}};
		directed_rows[12] = '{'{toeq_pkg::OP_POP, 32'h0, 8'h0, 8'h0}, 1'b1,
			'{toeq_pkg::ST_OK, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 7'd0}};
		directed_rows[13] = '{'{toeq_pkg::OP_POP, 32'h0, 8'h0, 8'h0}, 1'b1,
			'{toeq_pkg::ST_EMPTY, 1'b0, 32'h0, 8'h0, 8'h0, 7'd0}};
		directed_rows[14] = '{'{toeq_pkg::OP_INSERT, 32'h8000_0000, 8'hA5, 8'h5A}, 1'b0, '0};
		directed_rows[15] = '{'{toeq_pkg::OP_POP, 32'h0, 8'h0, 8'h0}, 1'b0, '0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		wait_all_results();

		run_phase(PHASE_ITEMS);
		wait_all_results();
		sender_idle_pct = 82;
		run_phase(PHASE_ITEMS);
		wait_all_results();
		sender_idle_pct = 0;
		run_phase(PHASE_ITEMS);

		wait_all_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("** time_ordered_event_queue: PASSED **");
		else
			$display("** time_ordered_event_queue: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
src/toeq_pkg.sv
src/toeq_cell.sv
src/time_ordered_event_queue.sv
tb/time_ordered_event_queue_tb.sv
